FILE: hw/rtl/wvsa_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the wormhole VC switch allocator.
// Used by wvsa_ctrl, wvsa_dp and the top level; depends on nothing.
package wvsa_pkg;

    // Router shape.
    localparam int NUM_PORTS = 5;
    localparam int NUM_CHANS = 2;
    localparam int NUM_ARBS  = NUM_PORTS * NUM_CHANS;

    // Widths of the port fields, of a port plus one carry bit, of a channel index, of an arbiter index.
    localparam int PORT_W = 3;
    localparam int SUM_W  = PORT_W + 1;
    localparam int CH_W   = (NUM_CHANS > 1) ? $clog2(NUM_CHANS) : 1;
    localparam int ARB_W  = (NUM_ARBS > 1) ? $clog2(NUM_ARBS) : 1;

    // Input command codes.
    localparam logic [1:0] CMD_REQ = 2'd0;
    localparam logic [1:0] CMD_RDY = 2'd1;
    localparam logic [1:0] CMD_ARB = 2'd2;

    // Result kind codes.
    localparam logic [1:0] KIND_REQ = 2'd0;
    localparam logic [1:0] KIND_ACK = 2'd1;
    localparam logic [1:0] KIND_NAK = 2'd2;

    // Input word.
    typedef struct packed {
        logic [1:0] command;
        logic [2:0] in_port;
        logic [2:0] out_port;
        logic       chan;
        logic       is_head;
        logic       is_tail;
        logic       ready_flag;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] target_port;
        logic       target_chan;
        logic       last;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              do_req;
        logic              do_rdy;
        logic              arb_en;
        logic              ref_en;
        logic              flush;
        logic [PORT_W-1:0] port;
        logic [CH_W-1:0]   chan;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       step_ok;
        logic       hold_empty;
        logic [1:0] item_cmd;
        logic       item_ok;
    } t_status;

    // Arbiter (or input port and channel) index: port-major, channel-minor.
    function automatic logic [ARB_W-1:0] arb_index(input logic [PORT_W-1:0] port,
                                                   input logic [CH_W-1:0] chan);
        return ARB_W'(32'(port) * NUM_CHANS + 32'(chan));
    endfunction

endpackage

FILE: hw/rtl/wormhole_vc_switch_allocator.sv
`timescale 1ns / 1ps
// Top level of the wormhole virtual-channel switch allocator.
// Depends on wvsa_pkg, wvsa_ctrl and wvsa_dp.
//
//   channel | valid        | stall        | word
//   --------+--------------+--------------+----------------------------
//   input   | i_in_valid   | o_in_stall   | i_in_word  (t_in_word)
//   output  | o_out_valid  | i_out_stall  | o_out_word (t_out_word)
//
// An in-range request is accepted, decoded and then flushed out of the hold stage; a
// readiness update or an ignored word is only accepted and decoded. An arbitrate tick
// is accepted and decoded, then walks each arbiter in the grant walk and then each
// input port and channel in the refusal walk, both through the single shared walk
// step, and ends with a flush.
// Reset is synchronous and active low and clears all arbiter state at once.
// Output stalls hold the walk whenever a new word would find the hold stage
// and the output register both full.
module wormhole_vc_switch_allocator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  wvsa_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output wvsa_pkg::t_out_word  o_out_word
);

    wvsa_pkg::t_cmd    cmd;
    wvsa_pkg::t_status status;

    // Sequencer.
    wvsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arbiter state and result stages.
    wvsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: hw/rtl/wvsa_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the switch allocator: decodes an item and walks the arbiters.
// Depends on wvsa_pkg; drives the datapath wvsa_dp through t_cmd.
module wvsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  wvsa_pkg::t_status i_status,
    output wvsa_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_ARB    = 3'd2;
    localparam logic [2:0] S_REF    = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [wvsa_pkg::PORT_W-1:0]  r_port, n_port;
    logic [wvsa_pkg::CH_W-1:0]    r_chan, n_chan;
    logic                         walk_last;
    logic                         chan_last;

    // Walk position flags.
    assign chan_last = (r_chan == wvsa_pkg::CH_W'(wvsa_pkg::NUM_CHANS - 1));
    assign walk_last = chan_last && (r_port == wvsa_pkg::PORT_W'(wvsa_pkg::NUM_PORTS - 1));

    // A new word is taken only between items.
    assign o_in_stall = (r_state != S_IDLE);

    // Next state, walk counters and commands.
    always_comb begin
        n_state     = r_state;
        n_port      = r_port;
        n_chan      = r_chan;
        o_cmd       = '0;
        o_cmd.port  = r_port;
        o_cmd.chan  = r_chan;
        unique case (r_state) inside
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_port = '0;
                n_chan = '0;
                unique case (i_status.item_cmd)
                    wvsa_pkg::CMD_REQ: begin
                        if (i_status.item_ok) begin
                            o_cmd.do_req = 1'b1;
                            if (i_status.step_ok) begin
                                n_state = S_FLUSH;
                            end
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    wvsa_pkg::CMD_RDY: begin
                        o_cmd.do_rdy = i_status.item_ok;
                        n_state      = S_IDLE;
                    end
                    wvsa_pkg::CMD_ARB: begin
                        n_state = S_ARB;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ARB, S_REF: begin
                o_cmd.arb_en = (r_state == S_ARB);
                o_cmd.ref_en = (r_state == S_REF);
                if (i_status.step_ok) begin
                    if (walk_last) begin
                        n_port  = '0;
                        n_chan  = '0;
                        n_state = (r_state == S_ARB) ? S_REF : S_FLUSH;
                    end else if (chan_last) begin
                        n_chan = '0;
                        n_port = r_port + wvsa_pkg::PORT_W'(1);
                    end else begin
                        n_chan = r_chan + wvsa_pkg::CH_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (i_status.hold_empty) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_port  <= '0;
            r_chan  <= '0;
        end else begin
            r_state <= n_state;
            r_port  <= n_port;
            r_chan  <= n_chan;
        end
    end

    // Nothing may be left in the hold stage once an item is finished.
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> i_status.hold_empty)
        else $error("hold stage not empty in idle");

    a_port_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_port) < wvsa_pkg::NUM_PORTS)
        else $error("walk port out of range");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_chan) < wvsa_pkg::NUM_CHANS)
        else $error("walk channel out of range");

endmodule

FILE: hw/rtl/wvsa_dp.sv
`timescale 1ns / 1ps
// Datapath of the switch allocator: arbiter state, round-robin pick, result stages.
// Depends on wvsa_pkg; commanded by wvsa_ctrl through t_cmd.
module wvsa_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wvsa_pkg::t_in_word   i_in_word,
    input  wvsa_pkg::t_cmd       i_cmd,
    output wvsa_pkg::t_status    o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output wvsa_pkg::t_out_word  o_out_word
);

    // Per-arbiter state, plus the open-request flag per input port and channel.
    logic [wvsa_pkg::NUM_PORTS-1:0] r_req     [wvsa_pkg::NUM_ARBS];
    logic [wvsa_pkg::NUM_PORTS-1:0] r_head    [wvsa_pkg::NUM_ARBS];
    logic [wvsa_pkg::NUM_PORTS-1:0] r_tail    [wvsa_pkg::NUM_ARBS];
    logic                           r_pending [wvsa_pkg::NUM_ARBS];
    logic                           r_worm    [wvsa_pkg::NUM_ARBS];
    logic [wvsa_pkg::PORT_W-1:0]    r_rr      [wvsa_pkg::NUM_ARBS];
    logic                           r_ready   [wvsa_pkg::NUM_ARBS];
    logic                           r_open    [wvsa_pkg::NUM_ARBS];

    wvsa_pkg::t_in_word   r_item;
    wvsa_pkg::t_out_word  r_hold_word, r_out_word, cand_word;
    logic                 r_hold_valid, n_hold_valid;
    logic                 r_out_valid, n_out_valid;

    logic [wvsa_pkg::ARB_W-1:0]     walk_idx, item_arb, item_src, grant_src;
    logic [wvsa_pkg::NUM_PORTS-1:0] cur_req, cur_head, cur_tail;
    logic [wvsa_pkg::PORT_W-1:0]    cur_rr, rr_port, grant_port;
    logic [wvsa_pkg::SUM_W-1:0]     rr_sum;
    logic                           cur_worm, rr_found, arb_work, arb_run, grant_valid;
    logic                           port_ok_in, port_ok_out, chan_ok, item_ok;
    logic                           cand_valid, out_free, step_ok, load_out, out_last;

    // Indexes of the walked arbiter and of the item's arbiter and input.
    assign walk_idx = wvsa_pkg::arb_index(i_cmd.port, i_cmd.chan);
    assign item_arb = wvsa_pkg::arb_index(r_item.out_port, wvsa_pkg::CH_W'(r_item.chan));
    assign item_src = wvsa_pkg::arb_index(r_item.in_port, wvsa_pkg::CH_W'(r_item.chan));

    // Range checks on the stored item.
    assign port_ok_in  = 32'(r_item.in_port) < wvsa_pkg::NUM_PORTS;
    assign port_ok_out = 32'(r_item.out_port) < wvsa_pkg::NUM_PORTS;
    assign chan_ok     = 32'(r_item.chan) < wvsa_pkg::NUM_CHANS;

    always_comb begin
        case (r_item.command)
            wvsa_pkg::CMD_REQ: item_ok = port_ok_in && port_ok_out && chan_ok;
            wvsa_pkg::CMD_RDY: item_ok = port_ok_out && chan_ok;
            wvsa_pkg::CMD_ARB: item_ok = 1'b1;
            default:           item_ok = 1'b0;
        endcase
    end

    // State of the walked arbiter.
    assign cur_req  = r_req[walk_idx];
    assign cur_head = r_head[walk_idx];
    assign cur_tail = r_tail[walk_idx];
    assign cur_rr   = r_rr[walk_idx];
    assign cur_worm = r_worm[walk_idx];

    // Round-robin search from the port after the last grant, wrapping once.
    always_comb begin
        rr_found = 1'b0;
        rr_port  = '0;
        rr_sum   = '0;
        for (int p = wvsa_pkg::NUM_PORTS - 1; p >= 0; p--) begin
            rr_sum = {1'b0, cur_rr} + wvsa_pkg::SUM_W'(p + 1);
            if (rr_sum >= wvsa_pkg::SUM_W'(wvsa_pkg::NUM_PORTS)) begin
                rr_sum = rr_sum - wvsa_pkg::SUM_W'(wvsa_pkg::NUM_PORTS);
            end
            if (cur_req[rr_sum[wvsa_pkg::PORT_W-1:0]]) begin
                rr_found = 1'b1;
                rr_port  = rr_sum[wvsa_pkg::PORT_W-1:0];
            end
        end
    end

    // A locked worm works only while its port requests; otherwise any pending request.
    assign arb_work    = cur_worm ? cur_req[cur_rr] : r_pending[walk_idx];
    assign arb_run     = arb_work && r_ready[walk_idx];
    assign grant_valid = arb_run && (cur_worm || rr_found);
    assign grant_port  = cur_worm ? cur_rr : rr_port;
    assign grant_src   = wvsa_pkg::arb_index(grant_port, i_cmd.chan);

    // Candidate result of this step.
    always_comb begin
        cand_valid = 1'b0;
        cand_word  = '0;
        if (i_cmd.do_req) begin
            cand_valid            = 1'b1;
            cand_word.kind        = wvsa_pkg::KIND_REQ;
            cand_word.target_port = r_item.out_port;
            cand_word.target_chan = r_item.chan;
        end else if (i_cmd.arb_en) begin
            cand_valid            = grant_valid;
            cand_word.kind        = wvsa_pkg::KIND_ACK;
            cand_word.target_port = grant_port;
            cand_word.target_chan = 1'(i_cmd.chan);
        end else if (i_cmd.ref_en) begin
            cand_valid            = r_open[walk_idx];
            cand_word.kind        = wvsa_pkg::KIND_NAK;
            cand_word.target_port = i_cmd.port;
            cand_word.target_chan = 1'(i_cmd.chan);
        end
    end

    // The hold stage keeps one word back so the final word can be marked last.
    assign out_free = !r_out_valid || !i_out_stall;
    assign step_ok  = !cand_valid || !r_hold_valid || out_free;

    always_comb begin
        n_out_valid  = r_out_valid && i_out_stall;
        n_hold_valid = r_hold_valid;
        load_out     = 1'b0;
        out_last     = 1'b0;
        if (cand_valid && step_ok) begin
            n_hold_valid = 1'b1;
            if (r_hold_valid) begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end
        end else if (i_cmd.flush && r_hold_valid && out_free) begin
            load_out     = 1'b1;
            out_last     = 1'b1;
            n_hold_valid = 1'b0;
            n_out_valid  = 1'b1;
        end
    end

    assign o_status    = {step_ok, !r_hold_valid, r_item.command, item_ok};
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Control state and arbiter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int a = 0; a < wvsa_pkg::NUM_ARBS; a++) begin
                r_req[a]     <= '0;
                r_head[a]    <= '0;
                r_tail[a]    <= '0;
                r_pending[a] <= 1'b0;
                r_worm[a]    <= 1'b0;
                r_rr[a]      <= '0;
                r_ready[a]   <= 1'b0;
                r_open[a]    <= 1'b0;
            end
        end else begin
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;

            // Record a request and open it at its input.
            if (i_cmd.do_req && step_ok) begin
                r_req[item_arb][r_item.in_port]  <= 1'b1;
                r_head[item_arb][r_item.in_port] <= r_item.is_head;
                r_tail[item_arb][r_item.in_port] <= r_item.is_tail;
                r_pending[item_arb]              <= 1'b1;
                r_open[item_src]                 <= 1'b1;
            end

            // Downstream readiness update.
            if (i_cmd.do_rdy) begin
                r_ready[item_arb] <= r_item.ready_flag;
            end

            // Run the walked arbiter.
            if (i_cmd.arb_en && arb_run && step_ok) begin
                r_pending[walk_idx] <= 1'b0;
                r_req[walk_idx]     <= '0;
                if (cur_worm) begin
                    if (cur_tail[cur_rr]) begin
                        r_worm[walk_idx] <= 1'b0;
                    end
                end else if (rr_found) begin
                    r_rr[walk_idx] <= rr_port;
                    if (cur_head[rr_port] && !cur_tail[rr_port]) begin
                        r_worm[walk_idx] <= 1'b1;
                    end
                end
                if (grant_valid) begin
                    r_open[grant_src] <= 1'b0;
                end
            end

            // Refuse a request still open.
            if (i_cmd.ref_en && cand_valid && step_ok) begin
                r_open[walk_idx] <= 1'b0;
            end
        end
    end

    // Item and word registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_word;
        end
        if (cand_valid && step_ok) begin
            r_hold_word <= cand_word;
        end
        if (load_out) begin
            r_out_word <= {r_hold_word.kind, r_hold_word.target_port,
                           r_hold_word.target_chan, out_last};
        end
    end

    // A held word pushed out by a new one lands in the output register.
    a_hold_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cand_valid && step_ok && r_hold_valid) |=> r_out_valid)
        else $error("held word lost on shift");

    a_grant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.arb_en && grant_valid) |-> (32'(grant_port) < wvsa_pkg::NUM_PORTS))
        else $error("grant to a port out of range");

    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.do_req, i_cmd.do_rdy, i_cmd.arb_en, i_cmd.ref_en, i_cmd.flush}))
        else $error("more than one datapath command");

endmodule

FILE: test/wormhole_vc_switch_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the wormhole virtual-channel switch allocator.
// Depends on wvsa_pkg and wormhole_vc_switch_allocator; a scoreboard class predicts each result word.
module wormhole_vc_switch_allocator_tb;
    import wvsa_pkg::*;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 3 + 2 * NUM_ARBS + 20;
    localparam int PHASE_ITEMS  = 140;

    // Arbiter state mirror, result prediction and result checking.
    class switch_alloc_sb;
        logic [NUM_PORTS-1:0] req_bits  [NUM_ARBS];
        logic [NUM_PORTS-1:0] head_bits [NUM_ARBS];
        logic [NUM_PORTS-1:0] tail_bits [NUM_ARBS];
        logic [PORT_W-1:0]    rr_ptr    [NUM_ARBS];
        bit                   pending   [NUM_ARBS];
        bit                   worm      [NUM_ARBS];
        bit                   out_rdy   [NUM_ARBS];
        bit                   open_req  [NUM_ARBS];
        t_out_word            awaited[$];
        int errors;
        int legal_words;
        int forwards;
        int grants;
        int refusals;

        function new();
            for (int a = 0; a < NUM_ARBS; a++) begin
                req_bits[a]  = '0;
                head_bits[a] = '0;
                tail_bits[a] = '0;
                rr_ptr[a]    = '0;
                pending[a]   = 1'b0;
                worm[a]      = 1'b0;
                out_rdy[a]   = 1'b0;
                open_req[a]  = 1'b0;
            end
            errors      = 0;
            legal_words = 0;
            forwards    = 0;
            grants      = 0;
            refusals    = 0;
        endfunction

        function t_out_word result_word(logic [1:0] kind, int port, int chan);
            t_out_word r;
            r.kind        = kind;
            r.target_port = PORT_W'(port);
            r.target_chan = 1'(chan);
            r.last        = 1'b0;
            return r;
        endfunction

        // Applies one accepted input word and queues the result words it causes.
        function void note_word(t_in_word w);
            t_out_word res_q[$];
            int a;
            int g;
            int rp;
            bit work;
            case (w.command)
                CMD_REQ: begin
                    if (w.in_port < NUM_PORTS && w.out_port < NUM_PORTS && w.chan < NUM_CHANS) begin
                        legal_words++;
                        a = w.out_port * NUM_CHANS + w.chan;
                        req_bits[a][w.in_port]  = 1'b1;
                        head_bits[a][w.in_port] = w.is_head;
                        tail_bits[a][w.in_port] = w.is_tail;
                        pending[a] = 1'b1;
                        open_req[w.in_port * NUM_CHANS + w.chan] = 1'b1;
                        res_q.push_back(result_word(KIND_REQ, w.out_port, w.chan));
                    end
                end
                CMD_RDY: begin
                    if (w.out_port < NUM_PORTS && w.chan < NUM_CHANS) begin
                        legal_words++;
                        out_rdy[w.out_port * NUM_CHANS + w.chan] = w.ready_flag;
                    end
                end
                CMD_ARB: begin
                    legal_words++;
                    // Grant walk: port outer, channel inner.
                    for (int p = 0; p < NUM_PORTS; p++) begin
                        for (int v = 0; v < NUM_CHANS; v++) begin
                            a = p * NUM_CHANS + v;
                            work = worm[a] ? req_bits[a][rr_ptr[a]] : pending[a];
                            if (work && out_rdy[a]) begin
                                pending[a] = 1'b0;
                                g = -1;
                                if (worm[a]) begin
                                    // A locked worm keeps its port until the tail.
                                    g = rr_ptr[a];
                                    if (tail_bits[a][rr_ptr[a]])
                                        worm[a] = 1'b0;
                                end else begin
                                    for (int k = 0; k < NUM_PORTS && g < 0; k++) begin
                                        rp = (int'(rr_ptr[a]) + 1 + k) % NUM_PORTS;
                                        if (req_bits[a][rp]) begin
                                            g = rp;
                                            rr_ptr[a] = PORT_W'(rp);
                                            if (head_bits[a][rp] && !tail_bits[a][rp])
                                                worm[a] = 1'b1;
                                        end
                                    end
                                end
                                req_bits[a] = '0;
                                if (g >= 0) begin
                                    res_q.push_back(result_word(KIND_ACK, g, v));
                                    open_req[g * NUM_CHANS + v] = 1'b0;
                                end
                            end
                        end
                    end
                    // Refusal walk over the requests still open.
                    for (int p = 0; p < NUM_PORTS; p++) begin
                        for (int v = 0; v < NUM_CHANS; v++) begin
                            if (open_req[p * NUM_CHANS + v]) begin
                                res_q.push_back(result_word(KIND_NAK, p, v));
                                open_req[p * NUM_CHANS + v] = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (res_q.size() > 0)
                res_q[res_q.size() - 1].last = 1'b1;
            foreach (res_q[i])
                awaited.push_back(res_q[i]);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch %0d at %0t: %s", errors, $time, msg);
        endtask

        // Compares one accepted result word with the oldest prediction.
        task check_word(t_out_word got);
            t_out_word want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected word kind=%0d port=%0d chan=%0d last=%0d",
                                 got.kind, got.target_port, got.target_chan, got.last));
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.target_port !== want.target_port)
                report($sformatf("target_port %0d, want %0d", got.target_port,
                                 want.target_port));
            if (got.target_chan !== want.target_chan)
                report($sformatf("target_chan %0d, want %0d", got.target_chan,
                                 want.target_chan));
            if (got.last !== want.last)
                report($sformatf("last %0d, want %0d", got.last, want.last));
            case (want.kind)
                KIND_REQ: forwards++;
                KIND_ACK: grants++;
                default:  refusals++;
            endcase
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    int send_idle_pct = 16;
    int recv_idle_pct = 67;
    int cycle_count   = 0;
    int words_sent    = 0;

    // Packet progress of the random traffic per input port and channel.
    bit pkt_open [NUM_PORTS][NUM_CHANS];
    int pkt_dest [NUM_PORTS][NUM_CHANS];

    switch_alloc_sb sb = new();

    wormhole_vc_switch_allocator uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, changed at the falling edge.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Result monitor at the rising edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(out_word);
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_in_word req_word(int ip, int op, int ch, bit hd, bit tl);
        t_in_word w;
        w          = '0;
        w.command  = CMD_REQ;
        w.in_port  = PORT_W'(ip);
        w.out_port = PORT_W'(op);
        w.chan     = 1'(ch);
        w.is_head  = hd;
        w.is_tail  = tl;
        return w;
    endfunction

    function automatic t_in_word rdy_word(int op, int ch, bit rdy);
        t_in_word w;
        w            = '0;
        w.command    = CMD_RDY;
        w.out_port   = PORT_W'(op);
        w.chan       = 1'(ch);
        w.ready_flag = rdy;
        return w;
    endfunction

    function automatic t_in_word tick_word();
        t_in_word w;
        w         = '0;
        w.command = CMD_ARB;
        return w;
    endfunction

    // Sends one word at the falling edge, after a random number of idle cycles.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_word  = w;
        do @(posedge clk); while (in_stall);
        sb.note_word(w);
        words_sent++;
        @(negedge clk);
    endtask

    // Well-formed packets with random content, plus readiness updates, ticks, noise and broken requests.
    task automatic run_random(input int goal);
        t_in_word w;
        int pick;
        int ip;
        int ch;
        bit hd;
        bit tl;
        while (sb.legal_words < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                w = $bits(t_in_word)'($urandom);
            end else if (pick < 22) begin
                w = rdy_word($urandom_range(0, NUM_PORTS - 1), $urandom_range(0, NUM_CHANS - 1),
                             $urandom_range(0, 99) < 80);
            end else if (pick < 30) begin
                w = req_word($urandom_range(0, NUM_PORTS - 1), $urandom_range(0, NUM_PORTS - 1),
                             $urandom_range(0, NUM_CHANS - 1), $urandom_range(0, 1),
                             $urandom_range(0, 1));
            end else if (pick < 76) begin
                ip = $urandom_range(0, NUM_PORTS - 1);
                ch = $urandom_range(0, NUM_CHANS - 1);
                if (!pkt_open[ip][ch]) begin
                    pkt_dest[ip][ch] = $urandom_range(0, NUM_PORTS - 1);
                    hd = 1'b1;
                    tl = ($urandom_range(0, 99) < 30);
                    pkt_open[ip][ch] = !tl;
                end else begin
                    // A stray head inside a packet must not disturb a locked worm.
                    hd = ($urandom_range(0, 99) < 5);
                    tl = ($urandom_range(0, 99) < 35);
                    pkt_open[ip][ch] = !tl;
                end
                w = req_word(ip, pkt_dest[ip][ch], ch, hd, tl);
            end else begin
                w = tick_word();
            end
            send_word(w);
        end
    endtask

    initial begin
        t_in_word junk;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty tick, then a refusal because the arbiter is not ready.
        send_word(tick_word());
        send_word(req_word(0, 0, 0, 1'b1, 1'b0));
        send_word(tick_word());
        // Single-flit packet from the highest port once the output is ready.
        send_word(rdy_word(0, 0, 1'b1));
        send_word(req_word(NUM_PORTS - 1, 0, 0, 1'b1, 1'b1));
        send_word(tick_word());
        // A worm locks the highest output and channel against a competitor.
        send_word(req_word(2, NUM_PORTS - 1, 1, 1'b1, 1'b0));
        send_word(rdy_word(NUM_PORTS - 1, 1, 1'b1));
        send_word(req_word(3, NUM_PORTS - 1, 1, 1'b1, 1'b0));
        send_word(tick_word());
        // Body with a stray head on the locked port, then the tail.
        send_word(req_word(3, NUM_PORTS - 1, 1, 1'b0, 1'b0));
        send_word(req_word(2, NUM_PORTS - 1, 1, 1'b1, 1'b0));
        send_word(tick_word());
        send_word(req_word(2, NUM_PORTS - 1, 1, 1'b0, 1'b1));
        send_word(req_word(3, NUM_PORTS - 1, 1, 1'b0, 1'b0));
        send_word(tick_word());
        // One input granted by two outputs: the second grant finds its request closed.
        send_word(req_word(1, 2, 0, 1'b0, 1'b0));
        send_word(req_word(1, 3, 0, 1'b0, 1'b0));
        send_word(rdy_word(2, 0, 1'b1));
        send_word(rdy_word(3, 0, 1'b1));
        send_word(tick_word());
        // A repeated request overwrites the recorded head and tail bits.
        send_word(req_word(0, 1, 1, 1'b1, 1'b0));
        send_word(req_word(0, 1, 1, 1'b0, 1'b1));
        // Out-of-range ports and the unused command are ignored.
        send_word(req_word(7, 0, 0, 1'b1, 1'b1));
        send_word(req_word(0, 7, 0, 1'b1, 1'b1));
        send_word(rdy_word(6, 1, 1'b1));
        junk = '1;
        junk.command = CMD_NONE;
        send_word(junk);

        // Random traffic under three pacing patterns.
        run_random(sb.legal_words + PHASE_ITEMS);
        send_idle_pct = 67;
        recv_idle_pct = 16;
        run_random(sb.legal_words + PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(sb.legal_words + PHASE_ITEMS);
        in_valid = 1'b0;

        // Drain, then give the block time to show any stray word.
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words (%0d legal) in %0d cycles over three pacing phases.",
                 words_sent, sb.legal_words, cycle_count);
        $display("Checked %0d forwarded requests, %0d grants and %0d refusals; %0d mismatches.",
                 sb.forwards, sb.grants, sb.refusals, sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/wvsa_pkg.sv
hw/rtl/wvsa_ctrl.sv
hw/rtl/wvsa_dp.sv
hw/rtl/wormhole_vc_switch_allocator.sv
test/wormhole_vc_switch_allocator_tb.sv
